FILE: rtl/dccsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccsm_pkg
// Shared types and constants for the service-mode CV programming sequencer.
// ----------------------------------------------------------------------------
package dccsm_pkg;

   localparam int unsigned ACTION_WIDTH  = 3;
   localparam int unsigned CV_NUM_WIDTH  = 11;
   localparam int unsigned CV_IDX_WIDTH  = 10;
   localparam int unsigned BIT_WIDTH     = 3;
   localparam int unsigned BYTE_WIDTH    = 8;
   localparam int unsigned ADDR_WIDTH    = 14;
   localparam int unsigned CMD_WIDTH     = 3;
   localparam int unsigned STEP_WIDTH    = 4;

   // request actions
   localparam logic [ACTION_WIDTH-1:0] ACT_READ_BYTE  = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE_BYTE = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE_BIT  = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_READ_BIT   = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE_ADDR = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_ACK_REPORT = 3'd5;

   // running command
   localparam logic [CMD_WIDTH-1:0] CMD_IDLE       = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_BYTE  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_BYTE = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_BIT  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_BIT   = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_ADDR = 3'd5;

   // packet instruction and data forms
   localparam logic [BYTE_WIDTH-1:0] INSTR_BIT_MANIP   = 8'h78;
   localparam logic [BYTE_WIDTH-1:0] INSTR_BYTE_VERIFY = 8'h74;
   localparam logic [BYTE_WIDTH-1:0] INSTR_BYTE_WRITE  = 8'h7C;
   localparam logic [BYTE_WIDTH-1:0] DATA_READ_BIT     = 8'hE8;
   localparam logic [BYTE_WIDTH-1:0] DATA_BIT_WRITE    = 8'hF0;
   localparam logic [BYTE_WIDTH-1:0] DATA_BIT_VERIFY   = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LONG_ADDR_PREFIX  = 8'hC0;

   localparam logic [CV_NUM_WIDTH-1:0] CV_NUM_MAX = 11'd1024;

   localparam logic [CV_IDX_WIDTH-1:0] CV_IDX_SHORT_ADDR = 10'(1 - 1);
   localparam logic [CV_IDX_WIDTH-1:0] CV_IDX_LONG_HIGH  = 10'(17 - 1);
   localparam logic [CV_IDX_WIDTH-1:0] CV_IDX_LONG_LOW   = 10'(18 - 1);
   localparam logic [CV_IDX_WIDTH-1:0] CV_IDX_CONFIG     = 10'(29 - 1);
   localparam logic [BIT_WIDTH-1:0]    CONFIG_LONG_BIT   = 3'd5;

   localparam logic [STEP_WIDTH-1:0] STEP_LONG_START  = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_SHORT_START = 4'd6;

   localparam logic [BYTE_WIDTH-1:0] LIMIT_RESET = 8'd127;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [CV_NUM_WIDTH-1:0] cv_number;
      logic [BIT_WIDTH-1:0]    bit_index;
      logic [BYTE_WIDTH-1:0]   data_value;
      logic [ADDR_WIDTH-1:0]   loco_address;
      logic                    acked;
   } req_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]    cmd;
      logic [STEP_WIDTH-1:0]   step;
      logic [CV_IDX_WIDTH-1:0] cv;
      logic [BYTE_WIDTH-1:0]   value;
      logic [BIT_WIDTH-1:0]    bit_sel;
      logic [ADDR_WIDTH-1:0]   address;
      logic                    all_ok;
   } state_type;

   localparam state_type STATE_RESET = '{
      cmd:     CMD_IDLE,
      step:    '0,
      cv:      '0,
      value:   '0,
      bit_sel: '0,
      address: '0,
      all_ok:  1'b1
   };

   typedef struct packed {
      logic                  is_packet;
      logic [BYTE_WIDTH-1:0] byte0;
      logic [BYTE_WIDTH-1:0] byte1;
      logic [BYTE_WIDTH-1:0] byte2;
      logic                  write_ack_window;
      logic                  done_ok;
      logic [BYTE_WIDTH-1:0] result_value;
   } rsp_type;

endpackage

FILE: rtl/dccsm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccsm_step
// Next-state and result logic for one request against the sequencer state.
// ----------------------------------------------------------------------------
module dccsm_step (
   input  dccsm_pkg::req_type   req,
   input  dccsm_pkg::state_type state,
   input  logic [7:0]           short_limit,
   output dccsm_pkg::state_type next_state,
   output logic                 rsp_fire,
   output dccsm_pkg::rsp_type   rsp
);
   import dccsm_pkg::*;

   function automatic rsp_type build_packet(state_type s);
      logic [CV_IDX_WIDTH-1:0] cv;
      logic                    use_write;
      logic                    is_bit;
      logic [BYTE_WIDTH-1:0]   val;
      logic [BIT_WIDTH-1:0]    bsel;
      logic                    phase;
      logic [BYTE_WIDTH-1:0]   instr;
      logic [BYTE_WIDTH-1:0]   data;
      logic                    win;
      logic [2:0]              sub;
      rsp_type                 r;
      cv        = s.cv;
      use_write = 1'b1;
      is_bit    = 1'b0;
      val       = s.value;
      bsel      = s.bit_sel;
      phase     = s.step[0];
      instr     = INSTR_BYTE_VERIFY;
      data      = s.value;
      win       = 1'b0;
      sub       = s.step[3:1];
      unique case (s.cmd)
         CMD_READ_BYTE, CMD_READ_BIT: begin
            use_write = 1'b0;
            if (!s.step[3]) begin
               instr = INSTR_BIT_MANIP;
               data  = DATA_READ_BIT | {5'b0, s.step[2:0]};
            end else begin
               instr = INSTR_BYTE_VERIFY;
               data  = s.value;
            end
         end
         CMD_WRITE_BYTE: begin
            is_bit = 1'b0;
         end
         CMD_WRITE_BIT: begin
            is_bit = 1'b1;
         end
         default: begin
            bsel = CONFIG_LONG_BIT;
            priority if (sub == 3'd0) begin
               cv  = CV_IDX_LONG_HIGH;
               val = LONG_ADDR_PREFIX | {2'b0, s.address[13:8]};
            end else if (sub == 3'd1) begin
               cv  = CV_IDX_LONG_LOW;
               val = s.address[7:0];
            end else if (sub == 3'd2) begin
               cv     = CV_IDX_CONFIG;
               is_bit = 1'b1;
               val    = 8'd1;
            end else if (sub == 3'd3) begin
               cv  = CV_IDX_SHORT_ADDR;
               val = s.address[7:0];
            end else begin
               cv     = CV_IDX_CONFIG;
               is_bit = 1'b1;
               val    = 8'd0;
            end
         end
      endcase
      if (use_write) begin
         win = !phase;
         if (is_bit) begin
            instr = INSTR_BIT_MANIP;
            data  = (phase ? DATA_BIT_VERIFY : DATA_BIT_WRITE) | {4'b0, val[0], bsel};
         end else begin
            instr = phase ? INSTR_BYTE_VERIFY : INSTR_BYTE_WRITE;
            data  = val;
         end
      end
      r.is_packet        = 1'b1;
      r.byte0            = instr | {6'b0, cv[9:8]};
      r.byte1            = cv[7:0];
      r.byte2            = data;
      r.write_ack_window = win;
      r.done_ok          = 1'b0;
      r.result_value     = '0;
      return r;
   endfunction

   function automatic rsp_type build_done(logic ok, logic [BYTE_WIDTH-1:0] val);
      rsp_type r;
      r                  = '0;
      r.done_ok          = ok;
      r.result_value     = ok ? val : '0;
      return r;
   endfunction

   state_type             upd;
   logic                  done;
   logic                  done_good;
   logic [BYTE_WIDTH-1:0] done_val;
   logic                  cv_bad;
   logic [2:0]            sub;
   logic                  last_sub;
   logic                  sub_finished;
   logic                  ok_next;

   always_comb begin
      upd          = state;
      rsp_fire     = 1'b0;
      done         = 1'b0;
      done_good    = 1'b0;
      done_val     = '0;
      cv_bad       = (req.cv_number == '0) || (req.cv_number > CV_NUM_MAX);
      sub          = state.step[3:1];
      last_sub     = (sub == 3'd2) || (sub >= 3'd4);
      sub_finished = !req.acked || state.step[0];
      ok_next      = state.all_ok & req.acked;

      if (req.action <= ACT_WRITE_ADDR) begin
         if (state.cmd == CMD_IDLE) begin
            rsp_fire = 1'b1;
            if (req.action == ACT_WRITE_ADDR) begin
               upd.cmd     = CMD_WRITE_ADDR;
               upd.address = req.loco_address;
               upd.all_ok  = 1'b1;
               upd.step    = (req.loco_address > {6'b0, short_limit}) ?
                             STEP_LONG_START : STEP_SHORT_START;
            end else if (cv_bad) begin
               done = 1'b1;
            end else begin
               upd.cv      = CV_IDX_WIDTH'(req.cv_number - 11'd1);
               upd.bit_sel = req.bit_index;
               upd.step    = '0;
               unique case (req.action)
                  ACT_READ_BYTE: begin
                     upd.cmd   = CMD_READ_BYTE;
                     upd.value = '0;
                  end
                  ACT_WRITE_BYTE: begin
                     upd.cmd   = CMD_WRITE_BYTE;
                     upd.value = req.data_value;
                  end
                  ACT_WRITE_BIT: begin
                     upd.cmd   = CMD_WRITE_BIT;
                     upd.value = {7'b0, req.data_value[0]};
                  end
                  default: begin
                     upd.cmd   = CMD_READ_BIT;
                     upd.value = '0;
                  end
               endcase
            end
         end
      end else if (req.action == ACT_ACK_REPORT && state.cmd != CMD_IDLE) begin
         rsp_fire = 1'b1;
         unique case (state.cmd)
            CMD_READ_BYTE, CMD_READ_BIT: begin
               if (!state.step[3]) begin
                  if (req.acked) begin
                     upd.value = state.value | (8'd1 << state.step[2:0]);
                  end
                  upd.step = state.step + 4'd1;
               end else begin
                  done      = 1'b1;
                  done_good = req.acked;
                  done_val  = (state.cmd == CMD_READ_BIT) ?
                              {7'b0, state.value[state.bit_sel]} : state.value;
               end
            end
            CMD_WRITE_BYTE, CMD_WRITE_BIT: begin
               if (state.step == '0 && req.acked) begin
                  upd.step = 4'd1;
               end else begin
                  done      = 1'b1;
                  done_good = req.acked && (state.step != '0);
                  done_val  = state.value;
               end
            end
            default: begin
               upd.all_ok = ok_next;
               if (sub_finished && last_sub) begin
                  done      = 1'b1;
                  done_good = ok_next;
                  done_val  = state.address[7:0];
               end else if (sub_finished) begin
                  upd.step = {sub + 3'd1, 1'b0};
               end else begin
                  upd.step = state.step + 4'd1;
               end
            end
         endcase
      end

      if (done) begin
         next_state = STATE_RESET;
         rsp        = build_done(done_good, done_val);
      end else begin
         next_state = upd;
         rsp        = build_packet(upd);
      end
   end

endmodule

FILE: rtl/dccsm_rsp_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccsm_rsp_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dccsm_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dccsm_pkg::rsp_type load_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output dccsm_pkg::rsp_type rsp_data,
   output logic               full_stalled
);
   import dccsm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_data     = data_ff;
   assign full_stalled = valid_ff & rsp_stall;

endmodule

FILE: rtl/dcc_service_mode_cv_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_service_mode_cv_sequencer_top
// Sequences DCC direct-mode CV programming packets from commands and
// acknowledge reports, and reports each command's completion.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless stalled. Each request is decided
// in the cycle it is taken, against the command state register, and its
// packet or completion report appears from the result register on the
// following cycle. The request side stalls only while that register holds a
// result and the response side stalls; requests with no result are still
// consumed. The short address limit is written via csr_wr_en / csr_wr_data.
module dcc_service_mode_cv_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [10:0] req_cv_number,
   input  logic [2:0]  req_bit_index,
   input  logic [7:0]  req_data_value,
   input  logic [13:0] req_loco_address,
   input  logic        req_acked,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_packet,
   output logic [7:0]  rsp_packet_byte0,
   output logic [7:0]  rsp_packet_byte1,
   output logic [7:0]  rsp_packet_byte2,
   output logic        rsp_write_ack_window,
   output logic        rsp_done_ok,
   output logic [7:0]  rsp_result_value,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import dccsm_pkg::*;

   logic [7:0] limit_ff;
   logic [7:0] limit_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  step_next;
   req_type    req;
   rsp_type    step_rsp;
   rsp_type    out_rsp;
   logic       step_fire;
   logic       accept;
   logic       busy;

   assign req = '{
      action:       req_action,
      cv_number:    req_cv_number,
      bit_index:    req_bit_index,
      data_value:   req_data_value,
      loco_address: req_loco_address,
      acked:        req_acked
   };

   assign req_stall = busy;
   assign accept    = req_valid & !busy;

   dccsm_step u_step (
      .req        (req),
      .state      (state_ff),
      .short_limit(limit_ff),
      .next_state (step_next),
      .rsp_fire   (step_fire),
      .rsp        (step_rsp)
   );

   dccsm_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (accept & step_fire),
      .load_data   (step_rsp),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (out_rsp),
      .full_stalled(busy)
   );

   assign state_in = accept ? step_next : state_ff;
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
      end
   end

   assign rsp_is_packet        = out_rsp.is_packet;
   assign rsp_packet_byte0     = out_rsp.byte0;
   assign rsp_packet_byte1     = out_rsp.byte1;
   assign rsp_packet_byte2     = out_rsp.byte2;
   assign rsp_write_ack_window = out_rsp.write_ack_window;
   assign rsp_done_ok          = out_rsp.done_ok;
   assign rsp_result_value     = out_rsp.result_value;

endmodule

FILE: tb/sv/dcc_service_mode_cv_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_service_mode_cv_sequencer_top_test
// Drives programming commands and acknowledge reports into the CV sequencer
// and predicts every packet and completion report it must return. Received
// transfers are checked field by field, in order, against the prediction.
// Covers rejected CV numbers, ignored and stray requests, and short and long
// address writes under several short address limits.
// ----------------------------------------------------------------------------
import dccsm_pkg::*;

class cv_sequence_scoreboard;
   logic [BYTE_WIDTH-1:0]   short_limit;
   logic [CMD_WIDTH-1:0]    cmd;
   logic [STEP_WIDTH-1:0]   step;
   logic [CV_IDX_WIDTH-1:0] cv;
   logic [BYTE_WIDTH-1:0]   value;
   logic [BIT_WIDTH-1:0]    bit_sel;
   logic [ADDR_WIDTH-1:0]   address;
   bit                      all_ok;
   rsp_type                 expected_replies[$];
   int                      replies_predicted;
   int                      errors;

   function new();
      short_limit = LIMIT_RESET;
      replies_predicted = 0;
      errors = 0;
      clear();
   endfunction

   function void clear();
      cmd = CMD_IDLE;
      step = '0;
      cv = '0;
      value = '0;
      bit_sel = '0;
      address = '0;
      all_ok = 1'b1;
   endfunction

   function bit busy();
      return cmd != CMD_IDLE;
   endfunction

   function int pending();
      return expected_replies.size();
   endfunction

   function rsp_type packet(logic [7:0] instr, logic [9:0] cvi, logic [7:0] data, bit win);
      rsp_type r;
      r = '0;
      r.is_packet = 1'b1;
      r.byte0 = instr | {6'b0, cvi[9:8]};
      r.byte1 = cvi[7:0];
      r.byte2 = data;
      r.write_ack_window = win;
      return r;
   endfunction

   function rsp_type completion(bit ok, logic [7:0] val);
      rsp_type r;
      r = '0;
      r.done_ok = ok;
      r.result_value = ok ? val : 8'd0;
      clear();
      return r;
   endfunction

   function rsp_type write_packet(logic [9:0] cvi, bit is_bit, logic [7:0] val,
                                  logic [2:0] bsel, bit verify);
      logic [7:0] manip;
      manip = {4'b0, val[0], bsel};
      if (is_bit)
         return packet(INSTR_BIT_MANIP, cvi,
                       (verify ? DATA_BIT_VERIFY : DATA_BIT_WRITE) | manip, !verify);
      return packet(verify ? INSTR_BYTE_VERIFY : INSTR_BYTE_WRITE, cvi, val, !verify);
   endfunction

   function rsp_type next_packet();
      logic [2:0] sub;
      sub = step[3:1];
      case (cmd)
         CMD_READ_BYTE, CMD_READ_BIT: begin
            if (step < 4'd8)
               return packet(INSTR_BIT_MANIP, cv, DATA_READ_BIT | {5'b0, step[2:0]}, 1'b0);
            return packet(INSTR_BYTE_VERIFY, cv, value, 1'b0);
         end
         CMD_WRITE_BYTE: return write_packet(cv, 1'b0, value, 3'd0, step[0]);
         CMD_WRITE_BIT:  return write_packet(cv, 1'b1, value, bit_sel, step[0]);
         default: begin
            case (sub)
               3'd0: return write_packet(CV_IDX_LONG_HIGH, 1'b0,
                                         LONG_ADDR_PREFIX | {2'b0, address[13:8]}, 3'd0, step[0]);
               3'd1: return write_packet(CV_IDX_LONG_LOW, 1'b0, address[7:0], 3'd0, step[0]);
               3'd2: return write_packet(CV_IDX_CONFIG, 1'b1, 8'd1, CONFIG_LONG_BIT, step[0]);
               3'd3: return write_packet(CV_IDX_SHORT_ADDR, 1'b0, address[7:0], 3'd0, step[0]);
               default: return write_packet(CV_IDX_CONFIG, 1'b1, 8'd0, CONFIG_LONG_BIT, step[0]);
            endcase
         end
      endcase
   endfunction

   function rsp_type acknowledge(bit ack);
      logic [2:0] sub;
      bit         last;
      bit         sub_done;
      sub = step[3:1];
      case (cmd)
         CMD_READ_BYTE, CMD_READ_BIT: begin
            if (step < 4'd8) begin
               if (ack)
                  value[step[2:0]] = 1'b1;
               step = step + 4'd1;
               return next_packet();
            end
            if (cmd == CMD_READ_BIT)
               return completion(ack, {7'b0, value[bit_sel]});
            return completion(ack, value);
         end
         CMD_WRITE_BYTE, CMD_WRITE_BIT: begin
            if (step == 4'd0 && ack) begin
               step = 4'd1;
               return next_packet();
            end
            return completion(ack && step != 4'd0, value);
         end
         default: begin
            last = (sub == 3'd2) || (sub >= 3'd4);
            if (!ack)
               all_ok = 1'b0;
            sub_done = !ack || step[0];
            if (sub_done && last)
               return completion(all_ok, address[7:0]);
            if (sub_done)
               step = {sub + 3'd1, 1'b0};
            else
               step = step + 4'd1;
            return next_packet();
         end
      endcase
   endfunction

   function void note_request(req_type r);
      rsp_type e;
      bit      replies;
      replies = 1'b0;
      if (r.action <= ACT_WRITE_ADDR) begin
         if (cmd == CMD_IDLE) begin
            replies = 1'b1;
            if (r.action == ACT_WRITE_ADDR) begin
               cmd = CMD_WRITE_ADDR;
               address = r.loco_address;
               all_ok = 1'b1;
               step = (r.loco_address > short_limit) ? STEP_LONG_START : STEP_SHORT_START;
               e = next_packet();
            end else if (r.cv_number == '0 || r.cv_number > CV_NUM_MAX) begin
               e = completion(1'b0, 8'd0);
            end else begin
               cv = CV_IDX_WIDTH'(r.cv_number - 11'd1);
               bit_sel = r.bit_index;
               step = '0;
               case (r.action)
                  ACT_READ_BYTE: begin
                     cmd = CMD_READ_BYTE;
                     value = '0;
                  end
                  ACT_WRITE_BYTE: begin
                     cmd = CMD_WRITE_BYTE;
                     value = r.data_value;
                  end
                  ACT_WRITE_BIT: begin
                     cmd = CMD_WRITE_BIT;
                     value = {7'b0, r.data_value[0]};
                  end
                  default: begin
                     cmd = CMD_READ_BIT;
                     value = '0;
                  end
               endcase
               e = next_packet();
            end
         end
      end else if (r.action == ACT_ACK_REPORT && cmd != CMD_IDLE) begin
         replies = 1'b1;
         e = acknowledge(r.acked);
      end
      if (replies) begin
         expected_replies.push_back(e);
         replies_predicted++;
      end
   endfunction

   function void compare(string field, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", field, want, seen);
         errors++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      if (expected_replies.size() == 0) begin
         $error("transfer received with no reply expected");
         errors++;
         return;
      end
      e = expected_replies.pop_front();
      compare("is_packet", e.is_packet, got.is_packet);
      compare("packet_byte0", e.byte0, got.byte0);
      compare("packet_byte1", e.byte1, got.byte1);
      compare("packet_byte2", e.byte2, got.byte2);
      compare("write_ack_window", e.write_ack_window, got.write_ack_window);
      compare("done_ok", e.done_ok, got.done_ok);
      compare("result_value", e.result_value, got.result_value);
   endfunction
endclass

module dcc_service_mode_cv_sequencer_top_test;

   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_LO = 3'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_HI = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_REPLIES = 375;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [10:0] req_cv_number = '0;
   logic [2:0]  req_bit_index = '0;
   logic [7:0]  req_data_value = '0;
   logic [13:0] req_loco_address = '0;
   logic        req_acked = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_packet;
   logic [7:0]  rsp_packet_byte0;
   logic [7:0]  rsp_packet_byte1;
   logic [7:0]  rsp_packet_byte2;
   logic        rsp_write_ack_window;
   logic        rsp_done_ok;
   logic [7:0]  rsp_result_value;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   cv_sequence_scoreboard sb = new();
   int cycle_count = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   dcc_service_mode_cv_sequencer_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_cv_number        (req_cv_number),
      .req_bit_index        (req_bit_index),
      .req_data_value       (req_data_value),
      .req_loco_address     (req_loco_address),
      .req_acked            (req_acked),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_packet        (rsp_is_packet),
      .rsp_packet_byte0     (rsp_packet_byte0),
      .rsp_packet_byte1     (rsp_packet_byte1),
      .rsp_packet_byte2     (rsp_packet_byte2),
      .rsp_write_ack_window (rsp_write_ack_window),
      .rsp_done_ok          (rsp_done_ok),
      .rsp_result_value     (rsp_result_value),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dcc_service_mode_cv_sequencer_top test failed");
         $finish;
      end
   end

   function automatic req_type make_item(logic [2:0] action, logic [10:0] cvn,
                                         logic [2:0] bsel, logic [7:0] data,
                                         logic [13:0] addr, logic acked);
      req_type r;
      r.action = action;
      r.cv_number = cvn;
      r.bit_index = bsel;
      r.data_value = data;
      r.loco_address = addr;
      r.acked = acked;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      pick;
      r = make_item(ACT_ACK_REPORT, 11'($urandom_range(1, 1024)), 3'($urandom),
                    8'($urandom), 14'($urandom), $urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
         0: r.loco_address = 14'($urandom_range(0, 255));
         1: r.loco_address = 14'(sb.short_limit) + 14'($urandom_range(0, 1));
         2: r.loco_address = $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0)
         r.cv_number = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 2047));
      pick = $urandom_range(0, 99);
      if (sb.busy()) begin
         if (pick >= 97)
            r.action = $urandom_range(0, 1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
         else if (pick >= 92)
            r.action = 3'($urandom_range(0, 4));
      end else begin
         if (pick < 85)
            r.action = 3'($urandom_range(0, 4));
         else if (pick >= 92)
            r.action = $urandom_range(0, 1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
      end
      return r;
   endfunction

   task automatic send(req_type r);
      int gap;
      if ($urandom_range(0, 29) == 0)
         req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= r.action;
      req_cv_number <= r.cv_number;
      req_bit_index <= r.bit_index;
      req_data_value <= r.data_value;
      req_loco_address <= r.loco_address;
      req_acked <= r.acked;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic send_ack(logic acked);
      send(make_item(ACT_ACK_REPORT, 11'($urandom), 3'($urandom), 8'($urandom),
                     14'($urandom), acked));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] limit);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      sb.short_limit = limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: check each transfer, then hold stall for a drawn count
   initial begin
      int hold;
      rsp_type got;
      hold = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got = '{is_packet: rsp_is_packet, byte0: rsp_packet_byte0,
                    byte1: rsp_packet_byte1, byte2: rsp_packet_byte2,
                    write_ack_window: rsp_write_ack_window, done_ok: rsp_done_ok,
                    result_value: rsp_result_value};
            sb.check_result(got);
            if ($urandom_range(0, 29) == 0)
               rsp_quiet = !rsp_quiet;
            hold = rsp_quiet ? 0 : $urandom_range(0, 4);
         end else if (hold != 0) begin
            hold--;
         end
         @(negedge clock);
         rsp_stall <= (hold != 0);
      end
   end

   initial begin
      int target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(make_item(ACT_ACK_REPORT, 11'd5, 3'd3, 8'hA5, 14'h2AAA, 1'b1));
      send(make_item(ACT_UNUSED_LO, 11'd1, 3'd0, 8'h00, 14'h0000, 1'b0));
      send(make_item(ACT_UNUSED_HI, 11'd2047, 3'd7, 8'hFF, 14'h3FFF, 1'b1));
      send(make_item(ACT_READ_BYTE, 11'd0, 3'd0, 8'h00, 14'h0000, 1'b0));
      send(make_item(ACT_READ_BIT, 11'd2047, 3'd7, 8'hFF, 14'h3FFF, 1'b1));
      send(make_item(ACT_WRITE_BYTE, 11'd1025, 3'd1, 8'h5A, 14'h1555, 1'b0));
      send(make_item(ACT_WRITE_BIT, 11'd0, 3'd2, 8'h01, 14'h0001, 1'b1));
      send(make_item(ACT_WRITE_BYTE, 11'd1024, 3'd0, 8'hFF, 14'h0000, 1'b0));
      send_ack(1'b1);
      send_ack(1'b1);
      send(make_item(ACT_WRITE_BIT, 11'd1, 3'd7, 8'h01, 14'h0000, 1'b0));
      send(make_item(ACT_WRITE_ADDR, 11'd3, 3'd0, 8'h00, 14'h0003, 1'b0));
      send_ack(1'b0);
      send(make_item(ACT_READ_BIT, 11'd1024, 3'd7, 8'h00, 14'h0000, 1'b0));
      repeat (9) send_ack(1'b1);
      send(make_item(ACT_WRITE_ADDR, 11'd0, 3'd0, 8'h00, 14'h3FFF, 1'b0));
      repeat (3) send_ack(1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_limit(8'd0);
            1: write_limit(8'd255);
            default: write_limit(8'($urandom_range(0, 255)));
         endcase
         target = sb.replies_predicted + PHASE_REPLIES;
         while (sb.replies_predicted < target)
            send(random_item());
         while (sb.busy())
            send_ack($urandom_range(0, 3) != 0);
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("dcc_service_mode_cv_sequencer_top test passed");
      else
         $display("dcc_service_mode_cv_sequencer_top test failed");
      $finish;
   end

endmodule
